// File: rtl/pgl_pkg.sv
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared types and constants of the palette gradient lookup.
// ----------------------------------------------------------------------------
package pgl_pkg;

  localparam int PALETTE_ENTRIES = 8;
  localparam int FRACTION_BITS   = 16;
  localparam int REG_COUNT       = 8;
  localparam int POS_W           = 18;
  localparam int CH_W            = 8;
  localparam int NUM_CH          = 3;
  localparam int COLOR_W         = NUM_CH * CH_W;
  localparam int IDX_W           = $clog2(REG_COUNT);
  localparam int SCALED_W        = FRACTION_BITS + IDX_W;
  localparam int WGT_W           = FRACTION_BITS + 1;
  localparam int PROD_W          = CH_W + WGT_W;

  localparam logic [IDX_W-1:0]         LAST_ENTRY = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0]         FIRST_ENTRY = '0;
  localparam logic [WGT_W-1:0]         ONE_VALUE  = WGT_W'(1) << FRACTION_BITS;
  localparam logic [PROD_W-1:0]        HALF_VALUE = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic [FRACTION_BITS-1:0] FRAC_MAX   = '1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [CH_W-1:0]          chan_t;
  typedef logic [POS_W-1:0]         pos_t;

  // Stage enables of the blend unit
  typedef struct packed {
    logic mul;
    logic sum;
  } blend_en_t;

endpackage

// File: rtl/pgl_index.sv
// ----------------------------------------------------------------------------
// pgl_index
// First stage: scale the position and split it into entry indexes and fraction.
// ----------------------------------------------------------------------------
module pgl_index (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pgl_pkg::pos_t position_i,
  output logic          valid_o,
  output pgl_pkg::idx_t lo_idx_o,
  output pgl_pkg::idx_t hi_idx_o,
  output pgl_pkg::frac_t frac_o
);
  import pgl_pkg::*;

  logic                valid_q;
  idx_t                lo_idx_d, lo_idx_q;
  idx_t                hi_idx_d, hi_idx_q;
  frac_t               frac_d, frac_q;
  logic                neg;
  logic                over;
  logic [SCALED_W-1:0] scaled;
  idx_t                idx_s;

  assign neg    = position_i[POS_W-1];
  assign over   = !neg && (position_i[POS_W-2:FRACTION_BITS] != '0);
  assign scaled = SCALED_W'(position_i[FRACTION_BITS-1:0]) * SCALED_W'(LAST_ENTRY);
  assign idx_s  = scaled[SCALED_W-1:FRACTION_BITS];

  always_comb begin
    lo_idx_d = idx_s;
    hi_idx_d = idx_s + idx_t'(1);
    frac_d   = scaled[FRACTION_BITS-1:0];
    if (neg) begin
      // unblended first entry
      lo_idx_d = FIRST_ENTRY;
      hi_idx_d = FIRST_ENTRY;
      frac_d   = '0;
    end else if (over) begin
      lo_idx_d = LAST_ENTRY;
      hi_idx_d = LAST_ENTRY;
      frac_d   = '0;
    end else if (idx_s >= LAST_ENTRY) begin
      lo_idx_d = LAST_ENTRY - idx_t'(1);
      hi_idx_d = LAST_ENTRY;
      frac_d   = FRAC_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_idx_q <= lo_idx_d;
      hi_idx_q <= hi_idx_d;
      frac_q   <= frac_d;
    end
  end

  assign valid_o  = valid_q;
  assign lo_idx_o = lo_idx_q;
  assign hi_idx_o = hi_idx_q;
  assign frac_o   = frac_q;

endmodule

// File: rtl/pgl_palette.sv
// ----------------------------------------------------------------------------
// pgl_palette
// Palette registers and the second stage that fetches the two blend colors.
// ----------------------------------------------------------------------------
module pgl_palette (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  pgl_pkg::idx_t  cfg_index_i,
  input  pgl_pkg::color_t cfg_data_i,
  input  logic           en_i,
  input  logic           valid_i,
  input  pgl_pkg::idx_t  lo_idx_i,
  input  pgl_pkg::idx_t  hi_idx_i,
  input  pgl_pkg::frac_t frac_i,
  output logic           valid_o,
  output pgl_pkg::color_t lo_color_o,
  output pgl_pkg::color_t hi_color_o,
  output pgl_pkg::frac_t frac_o
);
  import pgl_pkg::*;

  color_t palette_q [REG_COUNT];
  logic   valid_q;
  color_t lo_color_q;
  color_t hi_color_q;
  frac_t  frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < REG_COUNT; k++) begin
        palette_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      palette_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_color_q <= palette_q[lo_idx_i];
      hi_color_q <= palette_q[hi_idx_i];
      frac_q     <= frac_i;
    end
  end

  assign valid_o    = valid_q;
  assign lo_color_o = lo_color_q;
  assign hi_color_o = hi_color_q;
  assign frac_o     = frac_q;

endmodule

// File: rtl/pgl_blend.sv
// ----------------------------------------------------------------------------
// pgl_blend
// Third and fourth stages: weight both colors per channel, then sum and round.
// ----------------------------------------------------------------------------
module pgl_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pgl_pkg::blend_en_t en_i,
  input  logic              valid_i,
  input  pgl_pkg::color_t   lo_color_i,
  input  pgl_pkg::color_t   hi_color_i,
  input  pgl_pkg::frac_t    frac_i,
  output logic              valid_o,
  output pgl_pkg::color_t   color_o
);
  import pgl_pkg::*;

  logic              mul_valid_q;
  logic              sum_valid_q;
  logic [WGT_W-1:0]  wgt_lo;
  color_t            color_d, color_q;

  assign wgt_lo = ONE_VALUE - WGT_W'(frac_i);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [PROD_W-1:0] lo_prod_q;
    logic [PROD_W-1:0] hi_prod_q;
    logic [PROD_W-1:0] sum;

    always_ff @(posedge clk_i) begin
      if (en_i.mul) begin
        lo_prod_q <= PROD_W'(lo_color_i[c*CH_W +: CH_W]) * PROD_W'(wgt_lo);
        hi_prod_q <= PROD_W'(hi_color_i[c*CH_W +: CH_W]) * PROD_W'(frac_i);
      end
    end

    // round half up, then drop the fraction
    assign sum = lo_prod_q + hi_prod_q + HALF_VALUE;
    assign color_d[c*CH_W +: CH_W] = sum[FRACTION_BITS +: CH_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (en_i.mul) begin
        mul_valid_q <= valid_i;
      end
      if (en_i.sum) begin
        sum_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      color_q <= color_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign color_o = color_q;

endmodule

// File: rtl/palette_gradient_lookup.sv
// ----------------------------------------------------------------------------
// palette_gradient_lookup
// Color palette lookup with linear blending between adjacent entries.
// ----------------------------------------------------------------------------
// Four-stage pipeline: index split, palette fetch, channel multiply, sum and
// round. A position beat enters every cycle while in_stall_o is low; each
// stage holds only while the stage after it is full and stalled, so bubbles
// collapse and a stalled output costs no throughput until the pipeline is
// full. Palette registers are read in the fetch stage, so write them only
// while no beat is in flight. A negative position gives entry 0, a position
// of one or more gives the last entry.
module palette_gradient_lookup (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  pgl_pkg::idx_t   cfg_index_i,
  input  pgl_pkg::color_t cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pgl_pkg::pos_t   position_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pgl_pkg::chan_t  red_o,
  output pgl_pkg::chan_t  green_o,
  output pgl_pkg::chan_t  blue_o
);
  import pgl_pkg::*;

  logic      en_idx, en_fetch;
  blend_en_t en_blend;
  logic      idx_valid, fetch_valid, mul_valid, out_valid;
  idx_t      lo_idx, hi_idx;
  frac_t     idx_frac, fetch_frac;
  color_t    lo_color, hi_color, color;

  pgl_index u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_idx),
    .valid_i    (in_valid_i),
    .position_i (position_i),
    .valid_o    (idx_valid),
    .lo_idx_o   (lo_idx),
    .hi_idx_o   (hi_idx),
    .frac_o     (idx_frac)
  );

  pgl_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .en_i        (en_fetch),
    .valid_i     (idx_valid),
    .lo_idx_i    (lo_idx),
    .hi_idx_i    (hi_idx),
    .frac_i      (idx_frac),
    .valid_o     (fetch_valid),
    .lo_color_o  (lo_color),
    .hi_color_o  (hi_color),
    .frac_o      (fetch_frac)
  );

  pgl_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_blend),
    .valid_i    (fetch_valid),
    .lo_color_i (lo_color),
    .hi_color_i (hi_color),
    .frac_i     (fetch_frac),
    .valid_o    (out_valid),
    .color_o    (color)
  );

  // Mirror the multiply-stage valid to build the enable chain
  logic mul_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en_blend.mul) begin
      mul_valid_q <= fetch_valid;
    end
  end
  assign mul_valid = mul_valid_q;

  // Advance a stage when it is empty or its successor advances
  assign en_blend.sum = !out_valid || !out_stall_i;
  assign en_blend.mul = !mul_valid || en_blend.sum;
  assign en_fetch     = !fetch_valid || en_blend.mul;
  assign en_idx       = !idx_valid || en_fetch;

  assign in_stall_o  = !en_idx;
  assign out_valid_o = out_valid;
  assign red_o       = color[2*CH_W +: CH_W];
  assign green_o     = color[CH_W +: CH_W];
  assign blue_o      = color[0 +: CH_W];

endmodule
